FILE: design/asl_pkg.sv
// Shared types and constants for the Annex B SPS/PPS locator.
package asl_pkg;

	localparam logic [7:0]  NAL_TYPE_MASK   = 8'h1F;
	localparam logic [4:0]  NAL_SPS         = 5'd7;
	localparam logic [4:0]  NAL_PPS         = 5'd8;
	localparam logic [7:0]  START_CODE_TAIL = 8'h01;
	localparam logic [23:0] RECENT_RESET    = 24'hFFFFFF;
	localparam int          SPS_MIN_LEN     = 4;

	typedef struct packed {
		logic        sps_found;
		logic [15:0] sps_offset;
		logic [15:0] sps_length;
		logic        pps_found;
		logic [15:0] pps_offset;
		logic [15:0] pps_length;
		logic [7:0]  profile_byte;
		logic [7:0]  compat_byte;
		logic [7:0]  level_byte;
		logic        header_ok;
	} res_t;

endpackage

FILE: design/asl_parser.sv
// Byte-wise start code scanner with SPS and PPS record keeping.
module asl_parser #(
	parameter int MAX_BYTES = 65536
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          step,
	input  logic [7:0]    data_byte,
	input  logic          last_byte,
	output asl_pkg::res_t res
);
	import asl_pkg::*;

	localparam int PW = $clog2(MAX_BYTES + 1);
	localparam int BW = $clog2(MAX_BYTES);

	typedef enum logic [1:0] {PH_SEARCH, PH_HEADER, PH_NAL} phase_t;

	phase_t          phase_q, phase_n;
	logic [PW-1:0]   pos_q;
	logic [23:0]     recent_q;
	logic [BW-1:0]   begin_q, begin_n;
	logic [4:0]      kind_q, kind_n;
	logic [23:0]     head_q, head_n;
	logic            sps_found_q, sps_found_n;
	logic [BW-1:0]   sps_off_q, sps_off_n;
	logic [PW-1:0]   sps_len_q, sps_len_n;
	logic [23:0]     sps_bytes_q, sps_bytes_n;
	logic            pps_found_q, pps_found_n;
	logic [BW-1:0]   pps_off_q, pps_off_n;
	logic [PW-1:0]   pps_len_q, pps_len_n;

	logic [7:0]      b1, b2, b3;
	logic            ovf, code;
	logic [BW-1:0]   idx, k;
	logic [PW-1:0]   p, close_end, len;
	logic            close_en;
	logic [23:0]     kept;

	assign b1   = recent_q[7:0];
	assign b2   = recent_q[15:8];
	assign b3   = recent_q[23:16];
	assign ovf  = (pos_q >= PW'(MAX_BYTES));
	assign idx  = BW'(pos_q);
	assign k    = idx - begin_q;
	assign p    = PW'(idx) - PW'(2);
	assign code = (data_byte == START_CODE_TAIL) && (b1 == 8'h00) && (b2 == 8'h00)
		&& !last_byte;

	always_comb begin
		phase_n   = phase_q;
		begin_n   = begin_q;
		kind_n    = kind_q;
		head_n    = head_q;
		close_en  = 1'b0;
		close_end = '0;
		if (ovf) begin
			// Bytes beyond the limit are not parsed; an open NAL ends at the limit.
			if (last_byte && phase_q == PH_NAL) begin
				close_en  = 1'b1;
				close_end = PW'(MAX_BYTES);
			end
		end else begin
			case (phase_q)
				PH_HEADER: begin
					begin_n = idx;
					kind_n  = 5'(data_byte & NAL_TYPE_MASK);
					head_n  = '0;
					phase_n = PH_NAL;
				end
				PH_NAL: begin
					if (code) begin
						close_en = 1'b1;
						// A zero just before the start code belongs to it, not to the NAL.
						if (p > PW'(begin_q) && b3 == 8'h00)
							close_end = p - PW'(1);
						else
							close_end = p;
						phase_n = PH_HEADER;
					end else begin
						case (k)
							BW'(1):  head_n[23:16] = data_byte;
							BW'(2):  head_n[15:8]  = data_byte;
							BW'(3):  head_n[7:0]   = data_byte;
							default: ;
						endcase
					end
				end
				default: begin
					if (code)
						phase_n = PH_HEADER;
				end
			endcase
			if (last_byte && phase_n == PH_NAL) begin
				close_en  = 1'b1;
				close_end = PW'(idx) + PW'(1);
			end
		end
	end

	assign len = close_end - PW'(begin_n);

	always_comb begin
		kept = '0;
		if (len > PW'(1)) kept[23:16] = head_n[23:16];
		if (len > PW'(2)) kept[15:8]  = head_n[15:8];
		if (len > PW'(3)) kept[7:0]   = head_n[7:0];
	end

	always_comb begin
		sps_found_n = sps_found_q;
		sps_off_n   = sps_off_q;
		sps_len_n   = sps_len_q;
		sps_bytes_n = sps_bytes_q;
		pps_found_n = pps_found_q;
		pps_off_n   = pps_off_q;
		pps_len_n   = pps_len_q;
		if (close_en) begin
			if (kind_n == NAL_SPS) begin
				sps_found_n = 1'b1;
				sps_off_n   = begin_n;
				sps_len_n   = len;
				sps_bytes_n = kept;
			end else if (kind_n == NAL_PPS) begin
				pps_found_n = 1'b1;
				pps_off_n   = begin_n;
				pps_len_n   = len;
			end
		end
	end

	always_comb begin
		res.sps_found    = sps_found_n;
		res.sps_offset   = 16'(sps_off_n);
		res.sps_length   = 16'(sps_len_n);
		res.pps_found    = pps_found_n;
		res.pps_offset   = 16'(pps_off_n);
		res.pps_length   = 16'(pps_len_n);
		res.profile_byte = sps_bytes_n[23:16];
		res.compat_byte  = sps_bytes_n[15:8];
		res.level_byte   = sps_bytes_n[7:0];
		res.header_ok    = sps_found_n && pps_found_n && !ovf
			&& (sps_len_n >= PW'(SPS_MIN_LEN));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_SEARCH;
			pos_q       <= '0;
			recent_q    <= RECENT_RESET;
			begin_q     <= '0;
			kind_q      <= '0;
			head_q      <= '0;
			sps_found_q <= 1'b0;
			sps_off_q   <= '0;
			sps_len_q   <= '0;
			sps_bytes_q <= '0;
			pps_found_q <= 1'b0;
			pps_off_q   <= '0;
			pps_len_q   <= '0;
		end else if (step) begin
			if (last_byte) begin
				// The final byte closes the buffer; the next byte starts afresh.
				phase_q     <= PH_SEARCH;
				pos_q       <= '0;
				recent_q    <= RECENT_RESET;
				begin_q     <= '0;
				kind_q      <= '0;
				head_q      <= '0;
				sps_found_q <= 1'b0;
				sps_off_q   <= '0;
				sps_len_q   <= '0;
				sps_bytes_q <= '0;
				pps_found_q <= 1'b0;
				pps_off_q   <= '0;
				pps_len_q   <= '0;
			end else begin
				phase_q     <= phase_n;
				begin_q     <= begin_n;
				kind_q      <= kind_n;
				head_q      <= head_n;
				sps_found_q <= sps_found_n;
				sps_off_q   <= sps_off_n;
				sps_len_q   <= sps_len_n;
				sps_bytes_q <= sps_bytes_n;
				pps_found_q <= pps_found_n;
				pps_off_q   <= pps_off_n;
				pps_len_q   <= pps_len_n;
				if (!ovf) begin
					recent_q <= {recent_q[15:0], data_byte};
					pos_q    <= pos_q + PW'(1);
				end
			end
		end
	end

endmodule

FILE: design/annexb_sps_pps_locator.sv
// Top level of the Annex B SPS/PPS locator: input register, parser and result register.
// A byte accepted into the input register is parsed from there, and the result for a final
// byte is loaded into the result register when that byte advances out of the input register.
// Throughput: one byte per cycle; a byte that is not final always advances, and a final
// byte waits only while an earlier result is held and not yet taken.
// Reset clears all parser state and both valid flags.
module annexb_sps_pps_locator #(
	parameter int MAX_BYTES = 65536
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	input  logic        last_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        sps_found,
	output logic [15:0] sps_offset,
	output logic [15:0] sps_length,
	output logic        pps_found,
	output logic [15:0] pps_offset,
	output logic [15:0] pps_length,
	output logic [7:0]  profile_byte,
	output logic [7:0]  compat_byte,
	output logic [7:0]  level_byte,
	output logic        header_ok
);
	import asl_pkg::*;

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;
	logic       adv;
	logic       out_valid_q;
	res_t       res;
	res_t       res_q;

	assign adv      = valid_s1 && (!last_s1 || !out_valid_q || out_ready);
	assign in_ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= data_byte;
			last_s1 <= last_byte;
		end
	end

	asl_parser #(
		.MAX_BYTES(MAX_BYTES)
	) u_parser (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (adv),
		.data_byte(byte_s1),
		.last_byte(last_s1),
		.res      (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && last_s1)
			res_q <= res;
	end

	assign out_valid    = out_valid_q;
	assign sps_found    = res_q.sps_found;
	assign sps_offset   = res_q.sps_offset;
	assign sps_length   = res_q.sps_length;
	assign pps_found    = res_q.pps_found;
	assign pps_offset   = res_q.pps_offset;
	assign pps_length   = res_q.pps_length;
	assign profile_byte = res_q.profile_byte;
	assign compat_byte  = res_q.compat_byte;
	assign level_byte   = res_q.level_byte;
	assign header_ok    = res_q.header_ok;

endmodule

FILE: design/asl_checker.sv
// Port-level checks for the Annex B SPS/PPS locator, bound to the top level.
module asl_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic [7:0]  data_byte,
	input logic        last_byte,
	input logic        out_valid,
	input logic        out_ready,
	input logic        sps_found,
	input logic [15:0] sps_offset,
	input logic [15:0] sps_length,
	input logic        pps_found,
	input logic [15:0] pps_offset,
	input logic [15:0] pps_length,
	input logic [7:0]  profile_byte,
	input logic [7:0]  compat_byte,
	input logic [7:0]  level_byte,
	input logic        header_ok
);

	// A result that is not taken stays on the port unchanged.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(sps_offset) && $stable(sps_length)
			&& $stable(pps_offset) && $stable(pps_length) && $stable(header_ok))
		else $error("result changed while stalled");

	a_ok_needs_both: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && header_ok |-> sps_found && pps_found)
		else $error("header_ok without both parameter sets");

	a_sps_absent: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !sps_found |-> sps_offset == 16'd0 && sps_length == 16'd0
			&& profile_byte == 8'd0 && compat_byte == 8'd0 && level_byte == 8'd0)
		else $error("SPS record not cleared when absent");

	a_pps_absent: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !pps_found |-> pps_offset == 16'd0 && pps_length == 16'd0)
		else $error("PPS record not cleared when absent");

	a_short_sps: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && sps_found && (sps_length == 16'd0 || sps_length == 16'd1)
			|-> profile_byte == 8'd0 && compat_byte == 8'd0 && level_byte == 8'd0)
		else $error("SPS bytes reported beyond the NAL");

endmodule

bind annexb_sps_pps_locator asl_checker u_asl_checker (.*);

FILE: dv/tb_annexb_sps_pps_locator.sv
// Self-checking testbench for the Annex B SPS/PPS locator, with its own parser predictor.
`timescale 1ns / 100ps

module tb_annexb_sps_pps_locator;
	import asl_pkg::*;

	localparam int MAX_BYTES      = 65536;
	localparam int RANDOM_BYTES   = 1620;
	localparam int WATCHDOG_LIMIT = 1000;
	localparam int DRAIN_CYCLES   = 10;

	typedef enum logic [1:0] {PH_SEARCH, PH_HEADER, PH_NAL} parse_phase_t;

	typedef struct packed {
		logic [7:0] data;
		logic       is_last;
		logic       typed;
		res_t       want;
	} stim_row_t;

	localparam res_t RES_NONE = '0;
	localparam res_t RES_PAIR =
		'{1'b1, 16'd3, 16'd4, 1'b1, 16'd11, 16'd2, 8'h64, 8'h00, 8'h1F, 1'b1};
	localparam res_t RES_TAIL_CODE =
		'{1'b1, 16'd5, 16'd5, 1'b0, 16'd0, 16'd0, 8'hFF, 8'h00, 8'h00, 1'b0};
	localparam res_t RES_HEAD_LAST =
		'{1'b0, 16'd0, 16'd0, 1'b1, 16'd3, 16'd1, 8'h00, 8'h00, 8'h00, 1'b0};

	// Four short buffers: a lone byte, an SPS/PPS pair with a zero dropped before the
	// second start code, a start code whose tail is the final byte, and a final header.
	localparam stim_row_t DIRECTED_ROWS [28] = '{
		'{8'h00, 1'b1, 1'b1, RES_NONE},
		'{8'h00, 1'b0, 1'b0, RES_NONE},
		'{8'h00, 1'b0, 1'b0, RES_NONE},
		'{START_CODE_TAIL, 1'b0, 1'b0, RES_NONE},
		'{{3'b011, NAL_SPS}, 1'b0, 1'b0, RES_NONE},
		'{8'h64, 1'b0, 1'b0, RES_NONE},
		'{8'h00, 1'b0, 1'b0, RES_NONE},
		'{8'h1F, 1'b0, 1'b0, RES_NONE},
		'{8'h00, 1'b0, 1'b0, RES_NONE},
		'{8'h00, 1'b0, 1'b0, RES_NONE},
		'{8'h00, 1'b0, 1'b0, RES_NONE},
		'{START_CODE_TAIL, 1'b0, 1'b0, RES_NONE},
		'{{3'b011, NAL_PPS}, 1'b0, 1'b0, RES_NONE},
		'{8'hEE, 1'b1, 1'b1, RES_PAIR},
		'{8'hFF, 1'b0, 1'b0, RES_NONE},
		'{8'h00, 1'b0, 1'b0, RES_NONE},
		'{8'h00, 1'b0, 1'b0, RES_NONE},
		'{8'h00, 1'b0, 1'b0, RES_NONE},
		'{START_CODE_TAIL, 1'b0, 1'b0, RES_NONE},
		'{{3'b111, NAL_SPS}, 1'b0, 1'b0, RES_NONE},
		'{8'hFF, 1'b0, 1'b0, RES_NONE},
		'{8'h00, 1'b0, 1'b0, RES_NONE},
		'{8'h00, 1'b0, 1'b0, RES_NONE},
		'{START_CODE_TAIL, 1'b1, 1'b1, RES_TAIL_CODE},
		'{8'h00, 1'b0, 1'b0, RES_NONE},
		'{8'h00, 1'b0, 1'b0, RES_NONE},
		'{START_CODE_TAIL, 1'b0, 1'b0, RES_NONE},
		'{{3'b011, NAL_PPS}, 1'b1, 1'b1, RES_HEAD_LAST}
	};

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [7:0]  data_byte;
	logic        last_byte;
	logic        out_valid;
	logic        out_ready;
	logic        sps_found;
	logic [15:0] sps_offset;
	logic [15:0] sps_length;
	logic        pps_found;
	logic [15:0] pps_offset;
	logic [15:0] pps_length;
	logic [7:0]  profile_byte;
	logic [7:0]  compat_byte;
	logic [7:0]  level_byte;
	logic        header_ok;

	annexb_sps_pps_locator #(.MAX_BYTES(MAX_BYTES)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.data_byte(data_byte),
		.last_byte(last_byte),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.sps_found(sps_found),
		.sps_offset(sps_offset),
		.sps_length(sps_length),
		.pps_found(pps_found),
		.pps_offset(pps_offset),
		.pps_length(pps_length),
		.profile_byte(profile_byte),
		.compat_byte(compat_byte),
		.level_byte(level_byte),
		.header_ok(header_ok)
	);

	// Predictor state for the buffer being parsed.
	logic [16:0]  byte_pos;
	logic [23:0]  trail_bytes;
	parse_phase_t phase;
	logic [16:0]  nal_origin;
	logic [4:0]   nal_kind;
	logic [23:0]  head_bytes;
	logic         sps_seen;
	logic [16:0]  sps_at;
	logic [16:0]  sps_len;
	logic [23:0]  sps_head;
	logic         pps_seen;
	logic [16:0]  pps_at;
	logic [16:0]  pps_len;
	logic         overflow_seen;

	res_t       expected_headers[$];
	logic [7:0] buffer_bytes[$];
	int         error_count = 0;
	int         stalled_cycles = 0;

	task automatic clear_parser();
		byte_pos      = '0;
		trail_bytes   = RECENT_RESET;
		phase         = PH_SEARCH;
		nal_origin    = '0;
		nal_kind      = '0;
		head_bytes    = '0;
		sps_seen      = 1'b0;
		sps_at        = '0;
		sps_len       = '0;
		sps_head      = '0;
		pps_seen      = 1'b0;
		pps_at        = '0;
		pps_len       = '0;
		overflow_seen = 1'b0;
	endtask

	task automatic close_nal(input logic [16:0] end_pos);
		logic [16:0] len;
		logic [23:0] kept;
		len  = end_pos - nal_origin;
		kept = '0;
		// SPS bytes that lie beyond the end of the NAL are reported as zero.
		if (len > 1) kept[23:16] = head_bytes[23:16];
		if (len > 2) kept[15:8] = head_bytes[15:8];
		if (len > 3) kept[7:0] = head_bytes[7:0];
		if (nal_kind == NAL_SPS) begin
			sps_seen = 1'b1;
			sps_at   = nal_origin;
			sps_len  = len;
			sps_head = kept;
		end else if (nal_kind == NAL_PPS) begin
			pps_seen = 1'b1;
			pps_at   = nal_origin;
			pps_len  = len;
		end
	endtask

	task automatic parse_byte(input logic [7:0] data, input logic is_last,
			output logic emitted, output res_t summary);
		logic [7:0]  b1;
		logic [7:0]  b2;
		logic [7:0]  b3;
		logic        code;
		logic [16:0] p;
		logic [7:0]  masked;
		int          k;
		emitted = is_last;
		summary = '0;
		if (byte_pos >= MAX_BYTES) begin
			// Past the limit the position stays put and nothing more is parsed.
			overflow_seen = 1'b1;
			if (is_last && phase == PH_NAL) close_nal(17'(MAX_BYTES));
		end else begin
			b1   = trail_bytes[7:0];
			b2   = trail_bytes[15:8];
			b3   = trail_bytes[23:16];
			code = data == START_CODE_TAIL && b1 == 8'h00 && b2 == 8'h00 && !is_last;
			case (phase)
				PH_HEADER: begin
					masked     = data & NAL_TYPE_MASK;
					nal_origin = byte_pos;
					nal_kind   = masked[4:0];
					head_bytes = '0;
					phase      = PH_NAL;
				end
				PH_NAL: begin
					if (code) begin
						p = byte_pos - 17'd2;
						if (p > nal_origin && b3 == 8'h00) close_nal(p - 17'd1);
						else close_nal(p);
						phase = PH_HEADER;
					end else begin
						k = int'(byte_pos - nal_origin);
						if (k >= 1 && k <= 3) head_bytes[8 * (3 - k) +: 8] = data;
					end
				end
				default: begin
					if (code) phase = PH_HEADER;
				end
			endcase
			if (is_last && phase == PH_NAL) close_nal(byte_pos + 17'd1);
			trail_bytes = {trail_bytes[15:0], data};
			byte_pos    = byte_pos + 17'd1;
		end
		if (is_last) begin
			summary.sps_found    = sps_seen;
			summary.sps_offset   = sps_at[15:0];
			summary.sps_length   = sps_len[15:0];
			summary.pps_found    = pps_seen;
			summary.pps_offset   = pps_at[15:0];
			summary.pps_length   = pps_len[15:0];
			summary.profile_byte = sps_head[23:16];
			summary.compat_byte  = sps_head[15:8];
			summary.level_byte   = sps_head[7:0];
			summary.header_ok    = sps_seen && pps_seen && sps_len >= SPS_MIN_LEN &&
				!overflow_seen;
			clear_parser();
		end
	endtask

	task automatic report(input string msg);
		$display("%0t ns: %s", $time, msg);
		error_count++;
	endtask

	task automatic compare_field(input string name, input logic [15:0] got,
			input logic [15:0] want);
		if (got !== want)
			report($sformatf("%s is %0h, expected %0h", name, got, want));
	endtask

	task automatic check_header(input res_t got, input res_t want);
		compare_field("sps_found", 16'(got.sps_found), 16'(want.sps_found));
		compare_field("sps_offset", got.sps_offset, want.sps_offset);
		compare_field("sps_length", got.sps_length, want.sps_length);
		compare_field("pps_found", 16'(got.pps_found), 16'(want.pps_found));
		compare_field("pps_offset", got.pps_offset, want.pps_offset);
		compare_field("pps_length", got.pps_length, want.pps_length);
		compare_field("profile_byte", 16'(got.profile_byte), 16'(want.profile_byte));
		compare_field("compat_byte", 16'(got.compat_byte), 16'(want.compat_byte));
		compare_field("level_byte", 16'(got.level_byte), 16'(want.level_byte));
		compare_field("header_ok", 16'(got.header_ok), 16'(want.header_ok));
	endtask

	// Called at a falling edge; returns at the falling edge after the request is taken.
	task automatic send_byte(input logic [7:0] data, input logic is_last, input int gap,
			input logic typed, input res_t want);
		logic emitted;
		res_t predicted;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid  <= 1'b1;
		data_byte <= data;
		last_byte <= is_last;
		do @(posedge clk); while (!in_ready);
		parse_byte(data, is_last, emitted, predicted);
		if (emitted) expected_headers.push_back(typed ? want : predicted);
		@(negedge clk);
	endtask

	task automatic send_buffer(input logic no_gaps);
		foreach (buffer_bytes[i])
			send_byte(buffer_bytes[i], i == buffer_bytes.size() - 1,
				no_gaps ? 0 : $urandom_range(0, 12), 1'b0, RES_NONE);
	endtask

	function automatic logic [7:0] noise_byte();
		case ($urandom_range(0, 3))
			0: return 8'h00;
			1: return START_CODE_TAIL;
			default: return 8'($urandom);
		endcase
	endfunction

	function automatic logic [7:0] header_byte();
		logic [4:0] kind;
		case ($urandom_range(0, 7))
			0, 1: kind = NAL_SPS;
			2, 3: kind = NAL_PPS;
			default: kind = 5'($urandom);
		endcase
		return {3'($urandom), kind};
	endfunction

	task automatic push_start_code();
		buffer_bytes.push_back(8'h00);
		buffer_bytes.push_back(8'h00);
		buffer_bytes.push_back(START_CODE_TAIL);
	endtask

	// Mostly well-formed buffers of a few NALs; some pure noise, some that end on a
	// start code or on a bare header.
	task automatic build_random_buffer();
		int shape;
		int plen;
		shape = $urandom_range(0, 9);
		buffer_bytes.delete();
		if (shape == 0) begin
			repeat ($urandom_range(1, 24)) buffer_bytes.push_back(noise_byte());
		end else begin
			repeat ($urandom_range(0, 3)) buffer_bytes.push_back(noise_byte());
			repeat ($urandom_range(1, 4)) begin
				if ($urandom_range(0, 2) == 0) buffer_bytes.push_back(8'h00);
				push_start_code();
				buffer_bytes.push_back(header_byte());
				plen = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 2)
					: $urandom_range(3, 10);
				repeat (plen)
					buffer_bytes.push_back(($urandom_range(0, 3) == 0) ? 8'h00
						: 8'($urandom));
				if ($urandom_range(0, 2) == 0) buffer_bytes.push_back(8'h00);
			end
			if (shape == 1) begin
				push_start_code();
			end else if (shape == 2) begin
				push_start_code();
				buffer_bytes.push_back(header_byte());
			end
		end
	endtask

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			stalled_cycles <= 0;
		else
			stalled_cycles <= stalled_cycles + 1;
		if (stalled_cycles >= WATCHDOG_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (expected_headers.size() == 0)
				report("header summary arrived with none expected");
			else
				check_header({sps_found, sps_offset, sps_length, pps_found, pps_offset,
					pps_length, profile_byte, compat_byte, level_byte, header_ok},
					expected_headers.pop_front());
		end
	end

	// Result side: a random stall, possibly none, per result, sometimes held until the result is waiting.
	initial begin
		int   stall;
		logic hold_for_valid;
		out_ready = 1'b0;
		wait (arst_n);
		@(negedge clk);
		forever begin
			stall          = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 12);
			hold_for_valid = $urandom_range(0, 1);
			if (stall != 0) begin
				out_ready <= 1'b0;
				if (hold_for_valid)
					while (!out_valid) @(negedge clk);
				repeat (stall) @(negedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
			@(negedge clk);
		end
	end

	initial begin
		int random_count;
		random_count   = 0;
		arst_n         = 1'b0;
		in_valid       = 1'b0;
		data_byte      = 8'h00;
		last_byte      = 1'b0;
		clear_parser();
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (DIRECTED_ROWS[i])
			send_byte(DIRECTED_ROWS[i].data, DIRECTED_ROWS[i].is_last,
				$urandom_range(0, 12), DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].want);

		while (random_count < RANDOM_BYTES) begin
			build_random_buffer();
			random_count += buffer_bytes.size();
			send_buffer($urandom_range(0, 3) == 0);
		end

		in_valid <= 1'b0;
		while (expected_headers.size() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (error_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
